// File: rtl/http_message_tokenizer_unit_macros.svh
// Assertion macros shared by the tokenizer RTL files.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef HTTP_MESSAGE_TOKENIZER_UNIT_MACROS_SVH
`define HTTP_MESSAGE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define HMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define HMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hmt_pkg.sv
// Types and constants shared by the HTTP message tokenizer modules.
// No dependencies.
package hmt_pkg;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_START  = 2'd1,
    ST_BAD_HEADER = 2'd2,
    ST_NO_EOL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    KIND_FIELD0 = 3'd0,
    KIND_FIELD1 = 3'd1,
    KIND_FIELD2 = 3'd2,
    KIND_NAME   = 3'd3,
    KIND_VALUE  = 3'd4,
    KIND_BODY   = 3'd5,
    KIND_DONE   = 3'd6
  } kind_t;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    status_t     status;
    logic        last;
  } rec_t;

  // One queue entry holds everything a single byte produced.
  typedef struct packed {
    logic two;
    rec_t rec0;
    rec_t rec1;
  } work_t;

endpackage

// File: rtl/hmt_front.sv
// Front end: accepts message bytes, tracks the parse state and builds records.
// Depends on hmt_pkg and the assertion macro header.
`include "http_message_tokenizer_unit_macros.svh"

module hmt_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic           in_last_byte,
  output logic           push,
  output hmt_pkg::work_t push_item,
  input  logic           q_ready
);
  import hmt_pkg::*;

  typedef logic [OFFSET_BITS-1:0] off_t;
  localparam off_t OMAX = {OFFSET_BITS{1'b1}};

  function automatic off_t span_f(off_t a, off_t b);
    return (b > a) ? off_t'(b - a) : '0;
  endfunction

  phase_t     phase_r, phase_nxt, ph_step;
  off_t       pos_r, pos_nxt;
  off_t       tb_r, tb_nxt, tb_step;
  off_t       lb_r, lb_nxt, lb_step;
  logic [1:0] sp_r, sp_nxt, sp_step;
  logic       cr_r, cr_nxt, cr_step;
  logic       col_r, col_nxt, col_step;
  status_t    err_r, err_nxt, err_step;

  logic       accept;
  logic       tok_emit, tok_to_end, body_emit;
  kind_t      tok_kind;
  off_t       p_inc, p_dec;
  logic       active, is_crlf, line_short;
  rec_t       tok_rec, body_rec, done_rec;
  status_t    done_status;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  assign p_inc      = (pos_r == OMAX) ? pos_r : off_t'(pos_r + 1'b1);
  assign p_dec      = (pos_r == '0) ? '0 : off_t'(pos_r - 1'b1);
  assign active     = (phase_r == PH_START) || (phase_r == PH_HEADER);
  assign is_crlf    = cr_r && (in_data_byte == CH_LF);
  assign line_short = (pos_r <= lb_r) || (off_t'(pos_r - lb_r) == off_t'(1));

  // Next state.
  always_comb begin
    ph_step    = phase_r;
    tb_step    = tb_r;
    lb_step    = lb_r;
    sp_step    = sp_r;
    cr_step    = cr_r;
    col_step   = col_r;
    err_step   = err_r;
    tok_emit   = 1'b0;
    tok_kind   = KIND_FIELD0;
    tok_to_end = 1'b0;
    if (active) begin
      if (is_crlf) begin
        cr_step  = 1'b0;
        col_step = 1'b0;
        if (phase_r == PH_START) begin
          if (sp_r >= 2'd2) begin
            tok_emit   = 1'b1;
            tok_kind   = KIND_FIELD2;
            tok_to_end = 1'b1;
            ph_step    = PH_HEADER;
          end else begin
            ph_step  = PH_ERROR;
            err_step = ST_BAD_START;
          end
        end else if (line_short) begin
          ph_step = PH_BODY;
        end else if (sp_r != 2'd0) begin
          tok_emit   = 1'b1;
          tok_kind   = KIND_VALUE;
          tok_to_end = 1'b1;
        end else begin
          ph_step  = PH_ERROR;
          err_step = ST_BAD_HEADER;
        end
        lb_step = p_inc;
        tb_step = p_inc;
        sp_step = 2'd0;
      end else begin
        cr_step = (in_data_byte == CH_CR);
        if (phase_r == PH_START) begin
          if ((in_data_byte == CH_SP) && (sp_r < 2'd2)) begin
            tok_emit = 1'b1;
            tok_kind = (sp_r == 2'd0) ? KIND_FIELD0 : KIND_FIELD1;
            tb_step  = p_inc;
            sp_step  = sp_r + 2'd1;
          end
        end else if (col_r && (in_data_byte == CH_SP) && (sp_r == 2'd0)) begin
          tok_emit   = 1'b1;
          tok_kind   = KIND_NAME;
          tok_to_end = 1'b1;
          tb_step    = p_inc;
          sp_step    = 2'd1;
          col_step   = 1'b0;
        end else begin
          col_step = (in_data_byte == CH_COLON) && (sp_r == 2'd0);
        end
      end
    end

    if (in_last_byte) begin
      phase_nxt = PH_START;
      pos_nxt   = '0;
      tb_nxt    = '0;
      lb_nxt    = '0;
      sp_nxt    = 2'd0;
      cr_nxt    = 1'b0;
      col_nxt   = 1'b0;
      err_nxt   = ST_OK;
    end else begin
      phase_nxt = ph_step;
      pos_nxt   = p_inc;
      tb_nxt    = tb_step;
      lb_nxt    = lb_step;
      sp_nxt    = sp_step;
      cr_nxt    = cr_step;
      col_nxt   = col_step;
      err_nxt   = err_step;
    end
  end

  // Record outputs.
  always_comb begin
    body_emit = in_last_byte && (ph_step == PH_BODY);

    case (ph_step)
      PH_BODY:  done_status = ST_OK;
      PH_ERROR: done_status = err_step;
      default:  done_status = ST_NO_EOL;
    endcase

    tok_rec.kind   = tok_kind;
    tok_rec.start  = 16'(tb_r);
    tok_rec.length = 16'(span_f(tb_r, tok_to_end ? p_dec : pos_r));
    tok_rec.status = ST_OK;
    tok_rec.last   = 1'b0;

    body_rec.kind   = KIND_BODY;
    body_rec.start  = 16'(tb_step);
    body_rec.length = 16'(span_f(tb_step, p_inc));
    body_rec.status = ST_OK;
    body_rec.last   = 1'b0;

    done_rec.kind   = KIND_DONE;
    done_rec.start  = 16'd0;
    done_rec.length = 16'(p_inc);
    done_rec.status = done_status;
    done_rec.last   = 1'b1;

    push_item.rec0 = tok_emit ? tok_rec : (body_emit ? body_rec : done_rec);
    push_item.rec1 = done_rec;
    push_item.two  = (tok_emit || body_emit) && in_last_byte;
    push           = accept && (tok_emit || in_last_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      pos_r   <= '0;
      tb_r    <= '0;
      lb_r    <= '0;
      sp_r    <= 2'd0;
      cr_r    <= 1'b0;
      col_r   <= 1'b0;
      err_r   <= ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      tb_r    <= tb_nxt;
      lb_r    <= lb_nxt;
      sp_r    <= sp_nxt;
      cr_r    <= cr_nxt;
      col_r   <= col_nxt;
      err_r   <= err_nxt;
    end
  end

  `HMT_ASSERT_NEXT(a_last_clears, accept && in_last_byte, (pos_r == '0) && (phase_r == PH_START), "state not cleared after last byte")
  `HMT_ASSERT_NOW(a_error_quiet, accept && (phase_r == PH_ERROR), !tok_emit, "token emitted in error phase")

endmodule

// File: rtl/hmt_queue.sv
// Short queue of per-byte work entries between the front and back ends.
// Depends on hmt_pkg and the assertion macro header.
`include "http_message_tokenizer_unit_macros.svh"

module hmt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hmt_pkg::work_t push_item,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output hmt_pkg::work_t q_item
);
  import hmt_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  work_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign q_ready = (count_r < (AW+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `HMT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= (AW+1)'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// File: rtl/hmt_back.sv
// Back end: sends the records of queue entries one per cycle unless stalled.
// Depends on hmt_pkg and the assertion macro header.
`include "http_message_tokenizer_unit_macros.svh"

module hmt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  hmt_pkg::work_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output hmt_pkg::rec_t  out_rec
);
  import hmt_pkg::*;

  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r, out_rec_nxt;
  logic sec_valid_r, sec_valid_nxt;
  rec_t sec_r, sec_nxt;
  logic can_adv;

  assign can_adv   = !out_valid_r || out_ready;
  assign pop       = can_adv && !sec_valid_r && q_valid;
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rec_nxt   = out_rec_r;
    sec_valid_nxt = sec_valid_r;
    sec_nxt       = sec_r;
    if (can_adv) begin
      if (sec_valid_r) begin
        out_valid_nxt = 1'b1;
        out_rec_nxt   = sec_r;
        sec_valid_nxt = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        out_rec_nxt   = q_item.rec0;
        sec_valid_nxt = q_item.two;
        sec_nxt       = q_item.rec1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
    sec_r     <= sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  `HMT_ASSERT_NOW(a_second_behind_first, sec_valid_r, out_valid_r, "second record pending without a shown first")

endmodule

// File: rtl/http_message_tokenizer_unit.sv
// Top level of the HTTP/1.0 message tokenizer: front end, work queue, back end.
// Depends on hmt_pkg, hmt_front, hmt_queue and hmt_back.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    in_data_byte, in_last_byte
//   out_      output     out_valid / out_ready  out_token_kind, out_token_start,
//                                               out_token_length, out_parse_status,
//                                               out_last_result
//
// The front end takes one byte every cycle while the work queue has room.
// A byte yields zero, one or two records; the back end sends one record per cycle
// while out_ready is high, so a byte that closes a token and also ends the message
// has two records to send. Records pass through the queue and the output register.
// Reset (rst_n low at a clock edge) returns the parse state to the start line
// and empties the queue and the output register.
// A stall on the output fills the four-entry queue, after which in_ready drops.
module http_message_tokenizer_unit #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [1:0]  out_parse_status,
  output logic        out_last_result
);
  import hmt_pkg::*;

  // Work entries leaving the front end, one per byte that produces a record.
  logic  push;
  work_t push_item;
  logic  q_ready;

  // Entries handed from the queue to the back end.
  logic  pop;
  logic  q_valid;
  work_t q_item;

  rec_t  out_rec;

  hmt_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .push        (push),
    .push_item   (push_item),
    .q_ready     (q_ready)
  );

  hmt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  hmt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rec  (out_rec)
  );

  // The record register drives the result fields directly.
  assign out_token_kind   = out_rec.kind;
  assign out_token_start  = out_rec.start;
  assign out_token_length = out_rec.length;
  assign out_parse_status = out_rec.status;
  assign out_last_result  = out_rec.last;

endmodule

// File: tb/sv/http_token_checker.sv
// Checker for the HTTP message tokenizer: watches both channels, predicts token records.
// Depends on hmt_pkg for the record, kind, phase and status types.
// Hands its mismatch count and the number of records still owed to the testbench top.
module http_token_checker #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_token_kind,
  input  logic [15:0] out_token_start,
  input  logic [15:0] out_token_length,
  input  logic [1:0]  out_parse_status,
  input  logic        out_last_result,
  output int unsigned mismatch_count,
  output int unsigned pending_records
);
  import hmt_pkg::*;

  localparam int unsigned OFFSET_MAX = (32'd1 << OFFSET_BITS) - 1;

  // Predicted parser state.
  phase_t      phase;
  int unsigned byte_pos;
  int unsigned tok_start;
  int unsigned line_start;
  int unsigned splits;
  logic        after_cr;
  logic        after_colon;
  status_t     held_status;

  rec_t        expected_tokens[$];
  int unsigned record_index;

  initial begin
    mismatch_count = 0;
    pending_records = 0;
    record_index = 0;
  end

  function automatic int unsigned clamp_offset(int unsigned x);
    return (x >= OFFSET_MAX) ? OFFSET_MAX : x;
  endfunction

  function automatic int unsigned span_len(int unsigned a, int unsigned b);
    return (b > a) ? b - a : 0;
  endfunction

  function automatic void clear_state();
    phase = PH_START;
    byte_pos = 0;
    tok_start = 0;
    line_start = 0;
    splits = 0;
    after_cr = 1'b0;
    after_colon = 1'b0;
    held_status = ST_OK;
  endfunction

  function automatic void push_token(kind_t k, int unsigned s, int unsigned n, status_t st,
                                     logic lst);
    rec_t r;
    r.kind = k;
    r.start = s[15:0];
    r.length = n[15:0];
    r.status = st;
    r.last = lst;
    expected_tokens.push_back(r);
  endfunction

  // Advances the predicted parser by one byte and queues the records it closes.
  function automatic void tokenize_byte(logic [7:0] b, logic lst);
    int unsigned pos;
    int unsigned close_at;
    int unsigned total;
    kind_t       fk;
    status_t     st;
    pos = byte_pos;
    if (phase == PH_START || phase == PH_HEADER) begin
      if (after_cr && b == CH_LF) begin
        close_at = (pos > 0) ? pos - 1 : 0;
        after_cr = 1'b0;
        after_colon = 1'b0;
        if (phase == PH_START) begin
          if (splits >= 2) begin
            push_token(KIND_FIELD2, tok_start, span_len(tok_start, close_at), ST_OK, 1'b0);
            phase = PH_HEADER;
          end else begin
            phase = PH_ERROR;
            held_status = ST_BAD_START;
          end
        end else if (span_len(line_start, pos) <= 1) begin
          phase = PH_BODY;
        end else if (splits != 0) begin
          push_token(KIND_VALUE, tok_start, span_len(tok_start, close_at), ST_OK, 1'b0);
        end else begin
          phase = PH_ERROR;
          held_status = ST_BAD_HEADER;
        end
        line_start = clamp_offset(pos + 1);
        tok_start = line_start;
        splits = 0;
      end else begin
        after_cr = (b == CH_CR);
        if (phase == PH_START) begin
          if (b == CH_SP && splits < 2) begin
            fk = (splits == 0) ? KIND_FIELD0 : KIND_FIELD1;
            push_token(fk, tok_start, span_len(tok_start, pos), ST_OK, 1'b0);
            tok_start = clamp_offset(pos + 1);
            splits++;
          end
        end else if (after_colon && b == CH_SP && splits == 0) begin
          close_at = (pos > 0) ? pos - 1 : 0;
          push_token(KIND_NAME, tok_start, span_len(tok_start, close_at), ST_OK, 1'b0);
          tok_start = clamp_offset(pos + 1);
          splits = 1;
          after_colon = 1'b0;
        end else begin
          after_colon = (b == CH_COLON && splits == 0);
        end
      end
    end

    if (lst) begin
      total = clamp_offset(pos + 1);
      if (phase == PH_BODY) begin
        push_token(KIND_BODY, tok_start, span_len(tok_start, total), ST_OK, 1'b0);
        st = ST_OK;
      end else if (phase == PH_ERROR) begin
        st = held_status;
      end else begin
        st = ST_NO_EOL;
      end
      push_token(KIND_DONE, 0, total, st, 1'b1);
      clear_state();
    end else begin
      byte_pos = clamp_offset(pos + 1);
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s is %0d, predicted %0d",
                                record_index, name, got, want));
  endtask

  always @(posedge clk) begin
    rec_t want;
    if (!rst_n) begin
      clear_state();
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) tokenize_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("record %0d arrived with none owed (kind %0d)",
                                    record_index, out_token_kind));
        end else begin
          want = expected_tokens.pop_front();
          compare_field("kind", 16'(out_token_kind), 16'(want.kind));
          compare_field("start", out_token_start, want.start);
          compare_field("length", out_token_length, want.length);
          compare_field("status", 16'(out_parse_status), 16'(want.status));
          compare_field("last", 16'(out_last_result), 16'(want.last));
        end
        record_index++;
      end
    end
    pending_records <= expected_tokens.size();
  end

endmodule

// File: tb/sv/tb_http_message_tokenizer_unit.sv
// Testbench top for the HTTP message tokenizer: clock, reset, byte stimulus and verdict.
// Depends on hmt_pkg, http_message_tokenizer_unit and http_token_checker.
module tb_http_message_tokenizer_unit;
  import hmt_pkg::*;

  // Roughly how many random bytes the parser must actually act on.
  localparam int unsigned RANDOM_ITEMS = 1000;
  // Cycles to keep watching after the last owed record has arrived.
  localparam int unsigned SETTLE_CYCLES = 24;
  // Even with two records per byte and the longest stalls everywhere, a correct run
  // ends well before this limit, which leaves ample margin.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_IDLE = 17;

  // Message shapes for the random part; anything below MSG_NOISE is well formed.
  localparam int unsigned MSG_NOISE      = 6;
  localparam int unsigned MSG_BAD_START  = 7;
  localparam int unsigned MSG_BAD_HEADER = 8;
  localparam int unsigned MSG_CUT        = 9;

  localparam logic [7:0] CH_FILL_WORD = 8'h78;  // replaces separators inside words
  localparam logic [7:0] CH_FILL_TEXT = 8'h79;  // replaces a CR that could end a line
  localparam logic [7:0] CH_AFTER_CR  = 8'h7A;  // follows a deliberately lone CR

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [1:0]  out_parse_status;
  logic        out_last_result;

  int unsigned mismatch_count;
  int unsigned pending_records;

  http_message_tokenizer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_parse_status (out_parse_status),
    .out_last_result  (out_last_result)
  );

  // The checker sits beside the block, sees every handshake and owns all comparisons.
  http_token_checker token_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_parse_status (out_parse_status),
    .out_last_result  (out_last_result),
    .mismatch_count   (mismatch_count),
    .pending_records  (pending_records)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a record that is still owed.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side. After each accepted record the receiver draws a random stall of up to
  // MAX_IDLE, possibly none, and holds out_ready low through it. Now and then it switches
  // into a quiet stretch where it never stalls, so back-to-back records get exercised too.
  int unsigned stall_left = 0;
  bit          rx_quiet = 1'b0;
  always @(posedge clk) begin
    int unsigned stall;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 47) == 0) rx_quiet = !rx_quiet;
        stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (stall != 0) begin
          out_ready <= 1'b0;
          stall_left <= stall;
        end
      end else if (!out_ready) begin
        if (stall_left <= 1) out_ready <= 1'b1;
        else stall_left <= stall_left - 1;
      end
    end
  end

  // Byte side. A message is assembled into a queue first and then sent one item per
  // handshake, with the last byte flagged. Only bytes the parser acts on are counted.
  logic [7:0]  message_bytes[$];
  int unsigned message_live;
  int unsigned counted_bytes = 0;
  bit          tx_quiet = 1'b0;

  // Mostly uniform bytes, with separators and line-end characters drawn far more often
  // than chance would give them, so random content still hits the interesting paths.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0: return CH_SP;
      1: return CH_COLON;
      2: return CH_CR;
      3: return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Arbitrary bytes: used for bodies, noise and the ignored tail after an error.
  function automatic void add_any(int unsigned n);
    for (int unsigned i = 0; i < n; i++) message_bytes.push_back(pick_char());
  endfunction

  // A word holds no space, colon or CR, so it can neither split a line nor end one.
  function automatic void add_word(int unsigned n);
    logic [7:0] c;
    for (int unsigned i = 0; i < n; i++) begin
      c = pick_char();
      if (c == CH_SP || c == CH_COLON || c == CH_CR) c = CH_FILL_WORD;
      message_bytes.push_back(c);
    end
  endfunction

  // Free text for the rest of a line. A CR only appears alone, followed by a
  // non-LF byte, which the parser must keep as ordinary line content.
  function automatic void add_text(int unsigned n);
    logic [7:0] c;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        message_bytes.push_back(CH_CR);
        message_bytes.push_back(CH_AFTER_CR);
      end else begin
        c = pick_char();
        if (c == CH_CR) c = CH_FILL_TEXT;
        message_bytes.push_back(c);
      end
    end
  endfunction

  function automatic void add_crlf();
    message_bytes.push_back(CH_CR);
    message_bytes.push_back(CH_LF);
  endfunction

  // Builds one random message. Most are well formed with random content: a start line
  // with three fields, zero to three headers, a blank line and a short body. The rest
  // are noise, a start line short of two spaces, a header line with no colon-space
  // split, or a well-formed message cut off before its blank line is complete.
  // After an error the message gets a short tail of bytes the parser should ignore.
  function automatic void build_message();
    int unsigned variant;
    int unsigned headers;
    int unsigned cut;
    variant = $urandom_range(0, 9);
    message_bytes.delete();
    if (variant == MSG_NOISE) begin
      add_any($urandom_range(1, 20));
      message_live = message_bytes.size();
      return;
    end
    if (variant == MSG_BAD_START) begin
      add_word($urandom_range(0, 5));
      if ($urandom_range(0, 1) == 1) begin
        message_bytes.push_back(CH_SP);
        add_word($urandom_range(0, 5));
      end
      add_crlf();
      message_live = message_bytes.size();
      add_any($urandom_range(0, 4));
      return;
    end

    add_word($urandom_range(0, 5));
    message_bytes.push_back(CH_SP);
    add_word($urandom_range(0, 5));
    message_bytes.push_back(CH_SP);
    add_text($urandom_range(0, 8));
    add_crlf();
    headers = $urandom_range(0, 3);
    for (int unsigned h = 0; h < headers; h++) begin
      add_word($urandom_range(0, 5));
      message_bytes.push_back(CH_COLON);
      message_bytes.push_back(CH_SP);
      add_text($urandom_range(0, 8));
      add_crlf();
    end

    if (variant == MSG_BAD_HEADER) begin
      // At least one byte of content, so the line is not taken as the blank line.
      add_word($urandom_range(1, 5));
      if ($urandom_range(0, 1) == 1) message_bytes.push_back(CH_COLON);
      add_word($urandom_range(0, 3));
      add_crlf();
      message_live = message_bytes.size();
      add_any($urandom_range(0, 4));
      return;
    end

    add_crlf();
    if (variant == MSG_CUT) begin
      // The cut may land anywhere up to the CR of the blank line.
      cut = $urandom_range(1, message_bytes.size() - 1);
      message_bytes = message_bytes[0:cut - 1];
    end else begin
      add_any($urandom_range(0, 10));
    end
    message_live = message_bytes.size();
  endfunction

  // Offers one item. The gap before it is drawn per item; with a gap of zero valid
  // simply stays high into the next item, so it is never lowered and raised in one step.
  task automatic send_item(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_message();
    for (int unsigned i = 0; i < message_bytes.size(); i++)
      send_item(message_bytes[i], i == message_bytes.size() - 1);
    counted_bytes += message_live;
    message_bytes.delete();
  endtask

  // Holds the byte side off until the checker owes nothing. It always lowers valid before
  // it waits, which keeps valid from being dropped and raised in one step.
  task automatic wait_for_records();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_records != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed messages.
    // Two spaces right away give three empty start-line fields, and a blank line that
    // ends on the last byte gives an empty body with status ok.
    message_bytes = '{CH_SP, CH_SP, CH_CR, CH_LF, CH_CR, CH_LF};
    message_live = message_bytes.size();
    send_message();
    // Single-byte messages with the extreme byte values, both ending inside the start line.
    message_bytes = '{8'hFF};
    message_live = 1;
    send_message();
    message_bytes = '{8'h00};
    message_live = 1;
    send_message();
    // A lone LF and a lone CR are line content; one space gives a field token and then
    // a bad start line, flagged although the line ends on the last byte.
    message_bytes = '{CH_LF, CH_CR, CH_SP, CH_CR, CH_LF};
    message_live = message_bytes.size();
    send_message();
    // A header line with no colon-space split is a bad header; the byte after it is
    // ignored until the end of the message.
    message_bytes = '{CH_SP, CH_SP, CH_CR, CH_LF, 8'h68, CH_CR, CH_LF, 8'h71};
    message_live = 7;
    send_message();
    wait_for_records();

    // Random messages. Some are sent without gaps, and now and then the byte side
    // waits until every owed record is out, so the block also runs from empty.
    while (counted_bytes < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      build_message();
      send_message();
      if ($urandom_range(0, 7) == 0) wait_for_records();
    end

    // Drain, then watch a little longer for anything the block emits unasked.
    wait_for_records();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
